@@ hdl/bsoc_pkg.sv @@
// ----------------------------------------------------------------------------
// bsoc_pkg
// Shared widths, register indexes and stage payload types for the barometer
// second-order compensation core.
// ----------------------------------------------------------------------------
package bsoc_pkg;

    localparam int RAW_W   = 24;
    localparam int CAL_W   = 16;
    localparam int DT_W    = RAW_W + 1;
    localparam int TEMP_W  = 20;
    localparam int T2_W    = 17;
    localparam int OFF_W   = 42;
    localparam int SQ_W    = 38;
    localparam int OUT_W   = 32;
    localparam int IDX_W   = 3;

    localparam logic signed [TEMP_W-1:0] TEMP_LOW  = 20'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_VLOW = -20'sd1500;

    typedef enum logic [IDX_W-1:0] {
        REG_SENS       = 3'd0,
        REG_OFF        = 3'd1,
        REG_SENS_TC    = 3'd2,
        REG_OFF_TC     = 3'd3,
        REG_REF_TEMP   = 3'd4,
        REG_TEMP_SLOPE = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [CAL_W-1:0] sens;
        logic [CAL_W-1:0] off;
        logic [CAL_W-1:0] sens_tc;
        logic [CAL_W-1:0] off_tc;
        logic [CAL_W-1:0] ref_temp;
        logic [CAL_W-1:0] temp_slope;
    } t_cal;

    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [TEMP_W-1:0] temp;
        logic signed [OFF_W-1:0]  off;
        logic signed [OFF_W-1:0]  sens;
        logic [T2_W-1:0]          t2;
    } t_first;

    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [TEMP_W-1:0] temp;
        logic signed [OFF_W-1:0]  off;
        logic signed [OFF_W-1:0]  sens;
        logic                     low;
    } t_comp;

endpackage

@@ hdl/bsoc_first_order.sv @@
// ----------------------------------------------------------------------------
// bsoc_first_order
// Three stages: dT, the four dT products, then first-order TEMP, OFF, SENS
// and the T2 term.
// ----------------------------------------------------------------------------
module bsoc_first_order
    import bsoc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cal              i_cal,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [RAW_W-1:0]  i_d1,
    input  logic [RAW_W-1:0]  i_d2,
    output logic              o_valid,
    input  logic              i_ready,
    output t_first            o_data
);

    localparam int PW  = DT_W + CAL_W + 1;
    localparam int PDW = 2 * DT_W;

    logic                   r_va, r_vb, r_vc;
    logic                   en_a, en_b, en_c;

    logic [RAW_W-1:0]       r_a_d1;
    logic signed [DT_W-1:0] r_a_dt;
    logic signed [DT_W-1:0] n_a_dt;

    logic [RAW_W-1:0]       r_b_d1;
    logic signed [PW-1:0]   r_b_p6, r_b_p4, r_b_p3;
    logic signed [PDW-1:0]  r_b_pdd;
    logic signed [PW-1:0]   n_b_p6, n_b_p4, n_b_p3;
    logic signed [PDW-1:0]  n_b_pdd;

    t_first                 r_c;
    t_first                 n_c;

    assign en_c    = !r_vc || i_ready;
    assign en_b    = !r_vb || en_c;
    assign en_a    = !r_va || en_b;
    assign o_ready = en_a;
    assign o_valid = r_vc;
    assign o_data  = r_c;

    always_comb begin
        n_a_dt = $signed({1'b0, i_d2}) - $signed({1'b0, i_cal.ref_temp, 8'h00});
    end

    always_comb begin
        n_b_p6  = r_a_dt * $signed({1'b0, i_cal.temp_slope});
        n_b_p4  = r_a_dt * $signed({1'b0, i_cal.off_tc});
        n_b_p3  = r_a_dt * $signed({1'b0, i_cal.sens_tc});
        n_b_pdd = r_a_dt * r_a_dt;
    end

    // floor shifts are plain slices of the signed products
    always_comb begin
        n_c.d1   = r_b_d1;
        n_c.temp = TEMP_LOW + TEMP_W'($signed(r_b_p6[PW-1:23]));
        n_c.off  = OFF_W'($signed({1'b0, i_cal.off, 16'h0000}))
                 + OFF_W'($signed(r_b_p4[PW-1:7]));
        n_c.sens = OFF_W'($signed({1'b0, i_cal.sens, 15'h0000}))
                 + OFF_W'($signed(r_b_p3[PW-1:8]));
        n_c.t2   = r_b_pdd[31 +: T2_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (en_a) r_va <= i_valid;
            if (en_b) r_vb <= r_va;
            if (en_c) r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_d1 <= i_d1;
            r_a_dt <= n_a_dt;
        end
        if (en_b) begin
            r_b_d1  <= r_a_d1;
            r_b_p6  <= n_b_p6;
            r_b_p4  <= n_b_p4;
            r_b_p3  <= n_b_p3;
            r_b_pdd <= n_b_pdd;
        end
        if (en_c) begin
            r_c <= n_c;
        end
    end

endmodule

@@ hdl/bsoc_second_order.sv @@
// ----------------------------------------------------------------------------
// bsoc_second_order
// Two stages: the squared temperature distances, then T2, OFF2 and SENS2
// applied below 20.00 degrees, with the extra terms below -15.00 degrees.
// ----------------------------------------------------------------------------
module bsoc_second_order
    import bsoc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_first i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_comp  o_data
);

    localparam int SQF_W = 2 * TEMP_W;

    logic                     r_vd, r_ve;
    logic                     en_d, en_e;

    t_first                   r_d;
    logic [SQ_W-1:0]          r_d_hi, r_d_lo;
    logic                     r_d_low, r_d_vlow;
    logic signed [TEMP_W-1:0] n_d_hb, n_d_lb;
    logic signed [SQF_W-1:0]  n_d_hsq, n_d_lsq;

    logic [OFF_W-1:0]         n_e_hi, n_e_lo, n_e_off2, n_e_sens2;
    t_comp                    r_e;
    t_comp                    n_e;

    assign en_e    = !r_ve || i_ready;
    assign en_d    = !r_vd || en_e;
    assign o_ready = en_d;
    assign o_valid = r_ve;
    assign o_data  = r_e;

    always_comb begin
        n_d_hb  = i_data.temp - TEMP_LOW;
        n_d_lb  = i_data.temp - TEMP_VLOW;
        n_d_hsq = n_d_hb * n_d_hb;
        n_d_lsq = n_d_lb * n_d_lb;
    end

    // all terms are nonnegative, so the halvings truncate
    always_comb begin
        n_e_hi    = OFF_W'(r_d_hi);
        n_e_lo    = OFF_W'(r_d_lo);
        n_e_off2  = ((n_e_hi << 2) + n_e_hi) >> 1;
        n_e_sens2 = ((n_e_hi << 2) + n_e_hi) >> 2;
        if (r_d_vlow) begin
            n_e_off2  = n_e_off2 + (n_e_lo << 3) - n_e_lo;
            n_e_sens2 = n_e_sens2 + (((n_e_lo << 3) + (n_e_lo << 1) + n_e_lo) >> 1);
        end
        n_e.d1  = r_d.d1;
        n_e.low = r_d_low;
        if (r_d_low) begin
            n_e.temp = r_d.temp - $signed({{(TEMP_W-T2_W){1'b0}}, r_d.t2});
            n_e.off  = r_d.off - $signed(n_e_off2);
            n_e.sens = r_d.sens - $signed(n_e_sens2);
        end else begin
            n_e.temp = r_d.temp;
            n_e.off  = r_d.off;
            n_e.sens = r_d.sens;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
            r_ve <= 1'b0;
        end else begin
            if (en_d) r_vd <= i_valid;
            if (en_e) r_ve <= r_vd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_d) begin
            r_d      <= i_data;
            r_d_hi   <= n_d_hsq[SQ_W-1:0];
            r_d_lo   <= n_d_lsq[SQ_W-1:0];
            r_d_low  <= i_data.temp < TEMP_LOW;
            r_d_vlow <= i_data.temp < TEMP_VLOW;
        end
        if (en_e) begin
            r_e <= n_e;
        end
    end

endmodule

@@ hdl/bsoc_pressure.sv @@
// ----------------------------------------------------------------------------
// bsoc_pressure
// Two stages: D1 times SENS as two partial products, then the shifted sum,
// the offset and the final scaling to 32-bit results.
// ----------------------------------------------------------------------------
module bsoc_pressure
    import bsoc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  t_comp                   i_data,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [OUT_W-1:0] o_temp,
    output logic signed [OUT_W-1:0] o_pressure,
    output logic                    o_low
);

    localparam int SPLIT   = 21;
    localparam int MH_W    = RAW_W + 1 + OFF_W - SPLIT;
    localparam int ML_W    = RAW_W + SPLIT;
    localparam int Q_W     = MH_W + 2;
    localparam int P_SHIFT = 15;

    logic                     r_vf, r_vg;
    logic                     en_f, en_g;

    logic signed [MH_W-1:0]   r_f_mh, n_f_mh;
    logic [ML_W-1:0]          r_f_ml, n_f_ml;
    logic signed [OFF_W-1:0]  r_f_off;
    logic signed [TEMP_W-1:0] r_f_temp;
    logic                     r_f_low;

    logic signed [Q_W-1:0]    n_g_q;
    logic signed [OUT_W-1:0]  r_g_temp, r_g_p;
    logic                     r_g_low;

    assign en_g       = !r_vg || i_ready;
    assign en_f       = !r_vf || en_g;
    assign o_ready    = en_f;
    assign o_valid    = r_vg;
    assign o_temp     = r_g_temp;
    assign o_pressure = r_g_p;
    assign o_low      = r_g_low;

    // the upper partial product is an exact multiple of 2^SPLIT
    always_comb begin
        n_f_mh = $signed({1'b0, i_data.d1}) * $signed(i_data.sens[OFF_W-1:SPLIT]);
        n_f_ml = i_data.d1 * i_data.sens[SPLIT-1:0];
    end

    always_comb begin
        n_g_q = Q_W'(r_f_mh)
              + Q_W'($signed({1'b0, r_f_ml[ML_W-1:SPLIT]}))
              - Q_W'(r_f_off);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= 1'b0;
            r_vg <= 1'b0;
        end else begin
            if (en_f) r_vf <= i_valid;
            if (en_g) r_vg <= r_vf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_f) begin
            r_f_mh   <= n_f_mh;
            r_f_ml   <= n_f_ml;
            r_f_off  <= i_data.off;
            r_f_temp <= i_data.temp;
            r_f_low  <= i_data.low;
        end
        if (en_g) begin
            r_g_temp <= OUT_W'(r_f_temp);
            r_g_p    <= n_g_q[P_SHIFT +: OUT_W];
            r_g_low  <= r_f_low;
        end
    end

endmodule

@@ hdl/barometer_second_order_compensation_core.sv @@
// ----------------------------------------------------------------------------
// barometer_second_order_compensation_core
// Raw pressure and temperature conversions in, compensated temperature
// (0.01 degC) and pressure (0.01 mbar) out.
//
// Usage:
//   Load the six calibration words on the cfg channel (index 0..5, always
//   ready, out-of-range indexes ignored) while the pipeline is empty.
//   Each request on the s_axis channel carries one D1/D2 pair and yields
//   exactly one result on the m_axis channel.
//   One request is taken every cycle while the pipeline is not stalled;
//   the pipeline has seven register stages (dT, products, first-order
//   sums, squares, second-order terms, split D1*SENS product, final scale).
//   Each stage holds while its successor is full and stalled, so a stalled
//   receiver back-fills the empty stages before s_axis tready drops.
//   Synchronous reset empties the pipeline and clears the calibration
//   words to zero.
// ----------------------------------------------------------------------------
module barometer_second_order_compensation_core
    import bsoc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [IDX_W-1:0]       i_cfg_index,
    input  logic [CAL_W-1:0]       i_cfg_data,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [23:0] raw_pressure, [47:24] raw_temperature
    input  logic [2*RAW_W-1:0]     i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [31:0] temp_centideg, [63:32] pressure_centimbar
    output logic [2*OUT_W-1:0]     o_m_axis_tdata,
    // [0] low_temp_corrected
    output logic                   o_m_axis_tuser
);

    t_cal                    r_cal;
    logic                    fo_valid, fo_ready;
    t_first                  fo_data;
    logic                    so_valid, so_ready;
    t_comp                   so_data;
    logic signed [OUT_W-1:0] temp_out, pressure_out;

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = {pressure_out, temp_out};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_SENS:       r_cal.sens       <= i_cfg_data;
                REG_OFF:        r_cal.off        <= i_cfg_data;
                REG_SENS_TC:    r_cal.sens_tc    <= i_cfg_data;
                REG_OFF_TC:     r_cal.off_tc     <= i_cfg_data;
                REG_REF_TEMP:   r_cal.ref_temp   <= i_cfg_data;
                REG_TEMP_SLOPE: r_cal.temp_slope <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bsoc_first_order u_first (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cal   (r_cal),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_d1    (i_s_axis_tdata[RAW_W-1:0]),
        .i_d2    (i_s_axis_tdata[2*RAW_W-1:RAW_W]),
        .o_valid (fo_valid),
        .i_ready (fo_ready),
        .o_data  (fo_data)
    );

    bsoc_second_order u_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fo_valid),
        .o_ready (fo_ready),
        .i_data  (fo_data),
        .o_valid (so_valid),
        .i_ready (so_ready),
        .o_data  (so_data)
    );

    bsoc_pressure u_pressure (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (so_valid),
        .o_ready    (so_ready),
        .i_data     (so_data),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_temp     (temp_out),
        .o_pressure (pressure_out),
        .o_low      (o_m_axis_tuser)
    );

`ifndef SYNTHESIS
    // correction flag agrees with the reported temperature
    a_low_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser == (temp_out < OUT_W'(TEMP_LOW))))
        else $error("low_temp_corrected disagrees with temperature");

    // an empty output stage means every stage can take a request
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output stage");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && i_cfg_index == REG_REF_TEMP) |=> r_cal.ref_temp == $past(i_cfg_data))
        else $error("calibration write lost");
`endif

endmodule

@@ dv/tb_barometer_second_order_compensation_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_barometer_second_order_compensation_core
// Self-checking bench for the barometer compensation pipeline. Each accepted
// D1/D2 request is run through a 64-bit model of the datasheet math (first
// order, low-temperature and very-cold corrections, 32-bit wrap) and queued;
// every result on m_axis is compared with the oldest queued reading. The run
// steps through zero, full-scale, typical and random calibration sets, with
// random gaps on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_barometer_second_order_compensation_core
    import bsoc_pkg::*;
();

    localparam int  NUM_CAL       = 6;
    localparam int  RAND_PHASES   = 8;
    localparam int  PHASE_ITEMS   = 230;
    localparam int  HOLD_CYCLES   = 64;
    localparam int  DRAIN_CYCLES  = 20;
    localparam logic [RAW_W-1:0] RAW_MAX = '1;
    localparam logic [CAL_W-1:0] CAL_MAX = '1;

    typedef enum int {CAL_TYPICAL, CAL_ZERO, CAL_FULL, CAL_RANDOM} t_cal_kind;

    typedef struct {
        logic signed [OUT_W-1:0] temp;
        logic signed [OUT_W-1:0] pressure;
        logic                    low;
    } t_reading;

    class barometer_checker;
        longint   coeff[NUM_CAL];
        t_reading pending_readings[$];
        int       errors;
        int       n_checked;
        int       n_low;
        int       n_cold;

        function new();
            foreach (coeff[i]) coeff[i] = 0;
            errors    = 0;
            n_checked = 0;
            n_low     = 0;
            n_cold    = 0;
        endfunction

        function void set_coeff(logic [IDX_W-1:0] idx, logic [CAL_W-1:0] val);
            if (idx < NUM_CAL)
                coeff[idx] = longint'(val);
        endfunction

        // datasheet compensation at 64 bits, arithmetic shifts floor
        function void note_conversion(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
            longint   dt, temp, off, sens, t2, hi, lo, off2, sens2, p;
            t_reading r;
            dt   = longint'(d2) - coeff[REG_REF_TEMP] * 256;
            temp = 2000 + ((dt * coeff[REG_TEMP_SLOPE]) >>> 23);
            off  = coeff[REG_OFF] * 65536 + ((coeff[REG_OFF_TC] * dt) >>> 7);
            sens = coeff[REG_SENS] * 32768 + ((coeff[REG_SENS_TC] * dt) >>> 8);
            r.low = 1'b0;
            if (temp < 2000) begin
                t2    = (dt * dt) >>> 31;
                hi    = (temp - 2000) * (temp - 2000);
                off2  = 5 * hi / 2;
                sens2 = 5 * hi / 4;
                if (temp < -1500) begin
                    lo     = (temp + 1500) * (temp + 1500);
                    off2  += 7 * lo;
                    sens2 += 11 * lo / 2;
                    n_cold++;
                end
                r.low = 1'b1;
                n_low++;
                temp -= t2;
                off  -= off2;
                sens -= sens2;
            end
            p = (((longint'(d1) * sens) >>> 21) - off) >>> 15;
            r.temp     = temp[OUT_W-1:0];
            r.pressure = p[OUT_W-1:0];
            pending_readings.push_back(r);
        endfunction

        function void check_reading(logic [2*OUT_W-1:0] data, logic low);
            t_reading e;
            if (pending_readings.size() == 0) begin
                $error("result with no request outstanding: tdata=%h tuser=%b", data, low);
                errors++;
                return;
            end
            e = pending_readings.pop_front();
            n_checked++;
            if (data[OUT_W-1:0] !== e.temp) begin
                $error("temp_centideg: expected %0d, got %0d",
                       e.temp, $signed(data[OUT_W-1:0]));
                errors++;
            end
            if (data[2*OUT_W-1:OUT_W] !== e.pressure) begin
                $error("pressure_centimbar: expected %0d, got %0d",
                       e.pressure, $signed(data[2*OUT_W-1:OUT_W]));
                errors++;
            end
            if (low !== e.low) begin
                $error("low_temp_corrected: expected %0b, got %0b", e.low, low);
                errors++;
            end
        endfunction

        function void check_drained();
            if (pending_readings.size() != 0) begin
                $error("%0d expected readings never arrived", pending_readings.size());
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [IDX_W-1:0]     i_cfg_index;
    logic [CAL_W-1:0]     i_cfg_data;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [2*RAW_W-1:0]   i_s_axis_tdata;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [2*OUT_W-1:0]   o_m_axis_tdata;
    logic                 o_m_axis_tuser;

    barometer_checker sb;
    bit               gaps_on;
    bit               hold_req;
    int               n_settings;

    barometer_second_order_compensation_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.set_coeff(i_cfg_index, i_cfg_data);
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.note_conversion(i_s_axis_tdata[RAW_W-1:0],
                                   i_s_axis_tdata[2*RAW_W-1:RAW_W]);
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_reading(o_m_axis_tdata, o_m_axis_tuser);
        end
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int stall_left;
        stall_left      = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (stall_left > 0) begin
                i_m_axis_tready = 1'b0;
                stall_left--;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                i_m_axis_tready = 1'b0;
                stall_left      = pick_gap() - 1;
            end else begin
                i_m_axis_tready = 1'b1;
            end
        end
    end

    task automatic write_coeff(logic [IDX_W-1:0] idx, logic [CAL_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_calibration(t_cal_kind kind, logic [CAL_W-1:0] slope);
        logic [CAL_W-1:0] w[NUM_CAL];
        case (kind)
            CAL_TYPICAL: begin
                w = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, slope};
            end
            CAL_ZERO: begin
                w = '{default: '0};
            end
            CAL_FULL: begin
                w = '{default: CAL_MAX};
            end
            default: begin
                foreach (w[i]) w[i] = CAL_W'($urandom_range(0, 65535));
            end
        endcase
        write_coeff(REG_SENS,       w[0]);
        write_coeff(REG_OFF,        w[1]);
        write_coeff(REG_SENS_TC,    w[2]);
        write_coeff(REG_OFF_TC,     w[3]);
        write_coeff(REG_REF_TEMP,   w[4]);
        write_coeff(REG_TEMP_SLOPE, w[5]);
        // writes past the last register must be dropped
        if ($urandom_range(0, 1))
            write_coeff(IDX_W'(NUM_CAL + $urandom_range(0, 1)), CAL_W'($urandom));
        n_settings++;
    endtask

    task automatic send_conversion(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = pick_gap();
            repeat (gap) begin
                @(negedge i_clk);
                i_s_axis_tvalid = 1'b0;
            end
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {d2, d1};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (sb.pending_readings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [RAW_W-1:0] pick_d2();
        longint ctr, v;
        int     sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return RAW_W'($urandom);
        if (sel < 45)
            return $urandom_range(0, 1) ? RAW_MAX : '0;
        // near the reference temperature so both cold thresholds get crossed
        ctr = sb.coeff[REG_REF_TEMP] * 256;
        if (sel < 80)
            v = ctr + longint'($urandom_range(0, 1 << 22)) - (1 << 21);
        else
            v = ctr + longint'($urandom_range(0, 1 << 12)) - (1 << 11);
        if (v < 0)
            v = 0;
        if (v > longint'(RAW_MAX))
            v = longint'(RAW_MAX);
        return v[RAW_W-1:0];
    endfunction

    function automatic logic [RAW_W-1:0] pick_d1();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 80)
            return RAW_W'($urandom);
        if (sel < 90)
            return $urandom_range(0, 1) ? RAW_MAX : '0;
        return RAW_W'($urandom_range(8000000, 10000000));
    endfunction

    initial begin
        t_cal_kind        kind;
        logic [RAW_W-1:0] ref_d2;
        sb              = new();
        gaps_on         = 1'b1;
        hold_req        = 1'b0;
        n_settings      = 0;
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset calibration: all words zero
        send_conversion('0, '0);
        send_conversion(RAW_MAX, RAW_MAX);
        send_conversion(RAW_MAX, '0);
        send_conversion('0, RAW_MAX);
        wait_idle();

        // slope 2^15 puts the 20.00 and -15.00 degC edges on exact dT values
        load_calibration(CAL_TYPICAL, 16'd32768);
        write_coeff(IDX_W'(NUM_CAL), CAL_MAX);
        write_coeff(IDX_W'(NUM_CAL + 1), CAL_MAX);
        ref_d2 = RAW_W'(33464 * 256);
        send_conversion(24'd9085466, ref_d2);
        send_conversion(24'd9085466, ref_d2 - 24'd1);
        send_conversion(24'd9085466, ref_d2 - 24'd896000);
        send_conversion(24'd9085466, ref_d2 - 24'd896001);
        send_conversion(24'd9085466, '0);
        send_conversion(24'd9085466, RAW_MAX);
        send_conversion('0, ref_d2 - 24'd2000000);
        send_conversion(RAW_MAX, ref_d2 - 24'd2000000);
        send_conversion(RAW_MAX, ref_d2 + 24'd500000);
        wait_idle();

        load_calibration(CAL_FULL, CAL_MAX);
        send_conversion('0, '0);
        send_conversion(RAW_MAX, RAW_MAX);
        send_conversion(RAW_MAX, '0);
        send_conversion('0, RAW_MAX);
        send_conversion(24'h555555, 24'hAAAAAA);
        send_conversion(24'hAAAAAA, 24'h555555);
        wait_idle();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0:       kind = CAL_TYPICAL;
                3:       kind = CAL_FULL;
                6:       kind = CAL_ZERO;
                default: kind = CAL_RANDOM;
            endcase
            load_calibration(kind, 16'd28312);
            gaps_on = !(ph == 1 || ph == 2);
            if (ph == 1)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_conversion(pick_d1(), pick_d2());
            wait_idle();
            gaps_on = 1'b1;
        end

        sb.check_drained();
        $display("Checked %0d readings across %0d calibration sets.",
                 sb.n_checked, n_settings);
        $display("Low-temperature correction on %0d of them, very-cold term on %0d.",
                 sb.n_low, sb.n_cold);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/bsoc_pkg.sv
hdl/bsoc_first_order.sv
hdl/bsoc_second_order.sv
hdl/bsoc_pressure.sv
hdl/barometer_second_order_compensation_core.sv
dv/tb_barometer_second_order_compensation_core.sv
